FILE: rtl/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RESET = 5'd16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic load;   // latch the transaction, clear scan state
    logic scan;   // issue/evaluate one entry per cycle
    logic write;  // write-back and result
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

FILE: rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps

// Fully associative key/value cache with LRU replacement. A transaction is
// taken when start is high and busy is low; busy then stays high through
// the scan, which reads one entry per cycle of the clamped entries_in_use
// through the single read port of the entry memory, and the write-back
// state that follows it. A lookup
// produces its result on hit/found_value for exactly one cycle, flagged by
// result_valid, in the first cycle with busy low; the receiver cannot stall
// it, so it must take the result in that cycle. Inserts produce no result.
// Write entries_in_use only while the block is idle.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [lkvc_pkg::KEY_W-1:0]          key,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lkvc_pkg::CFG_W-1:0]          cfg_data,
  output logic                                result_valid,
  output logic                                hit,
  output logic signed [lkvc_pkg::VALUE_W-1:0] found_value
);

  lkvc_pkg::ctrl_cmd_t  cmd;
  lkvc_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .op           (op),
    .key          (key),
    .value        (value),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .hit          (hit),
    .found_value  (found_value)
  );

endmodule

FILE: rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps

module lkvc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  lkvc_pkg::dp_status_t  status,
  output lkvc_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: rtl/lkvc_datapath.sv
`timescale 1ns / 1ps

module lkvc_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lkvc_pkg::ctrl_cmd_t                cmd,
  output lkvc_pkg::dp_status_t               status,
  input  logic                               op,
  input  logic [lkvc_pkg::KEY_W-1:0]         key,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] value,
  input  logic                               cfg_we,
  input  logic [lkvc_pkg::CFG_W-1:0]         cfg_data,
  output logic                               result_valid,
  output logic                               hit,
  output logic signed [lkvc_pkg::VALUE_W-1:0] found_value
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [lkvc_pkg::KEY_W-1:0]   key;
    logic [lkvc_pkg::VALUE_W-1:0] value;
    logic [lkvc_pkg::STAMP_W-1:0] stamp;
  } entry_t;

  entry_t mem [ENTRIES];
  entry_t rd_data;
  entry_t wr_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  logic [ENTRIES-1:0] valid_bits;

  logic [lkvc_pkg::CFG_W-1:0]   entries_in_use;
  logic [CNT_W-1:0]             n_act;
  logic [lkvc_pkg::STAMP_W-1:0] tick;

  // latched transaction
  logic                         op_q;
  logic [lkvc_pkg::KEY_W-1:0]   key_q;
  logic [lkvc_pkg::VALUE_W-1:0] value_q;

  // scan pipeline: issue stage then evaluate stage
  logic [CNT_W-1:0] issue_cnt;
  logic             eval_vld;
  logic [IDX_W-1:0] eval_idx;

  logic                         match_found;
  logic [IDX_W-1:0]             match_idx;
  logic [lkvc_pkg::VALUE_W-1:0] match_value;
  logic                         empty_found;
  logic [IDX_W-1:0]             empty_idx;
  logic                         old_found;
  logic [IDX_W-1:0]             old_idx;
  logic [lkvc_pkg::STAMP_W-1:0] old_stamp;

  // out-of-range counts clamp to 1..ENTRIES
  always_comb begin
    if (entries_in_use == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(entries_in_use) > 32'(ENTRIES)) begin
      n_act = CNT_W'(ENTRIES);
    end else begin
      n_act = CNT_W'(entries_in_use);
    end
  end

  assign rd_addr          = issue_cnt[IDX_W-1:0];
  assign status.scan_done = (issue_cnt == n_act) && !eval_vld;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= lkvc_pkg::ENTRIES_IN_USE_RESET;
    end else if (cfg_we) begin
      entries_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
    end else if (cmd.load) begin
      tick <= tick + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      key_q   <= key;
      value_q <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      eval_vld  <= 1'b0;
    end else if (cmd.load) begin
      issue_cnt <= '0;
      eval_vld  <= 1'b0;
    end else if (cmd.scan) begin
      if (issue_cnt < n_act) begin
        issue_cnt <= issue_cnt + 1'b1;
        eval_vld  <= 1'b1;
        eval_idx  <= issue_cnt[IDX_W-1:0];
      end else begin
        eval_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_found <= 1'b0;
      empty_found <= 1'b0;
      old_found   <= 1'b0;
    end else if (cmd.scan && eval_vld) begin
      if (valid_bits[eval_idx]) begin
        if (!match_found && rd_data.key == key_q) begin
          match_found <= 1'b1;
          match_idx   <= eval_idx;
          match_value <= rd_data.value;
        end
        if (!old_found || rd_data.stamp < old_stamp) begin
          old_found <= 1'b1;
          old_idx   <= eval_idx;
          old_stamp <= rd_data.stamp;
        end
      end else if (!empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= eval_idx;
      end
    end
  end

  // write-back: a lookup hit only refreshes the stamp
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = match_idx;
    wr_data.key   = key_q;
    wr_data.value = value_q;
    wr_data.stamp = tick;
    if (cmd.write) begin
      if (op_q == lkvc_pkg::OP_LOOKUP) begin
        wr_en         = match_found;
        wr_data.value = match_value;
      end else begin
        wr_en = 1'b1;
        if (!match_found) begin
          wr_addr = empty_found ? empty_idx : old_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (cmd.write && op_q == lkvc_pkg::OP_INSERT && !match_found) begin
      valid_bits[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.write && (op_q == lkvc_pkg::OP_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      hit         <= match_found;
      found_value <= match_found ? match_value : '0;
    end
  end

endmodule

FILE: tb/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

  localparam int DEPTH        = 16;
  localparam int KEY_POOL     = 40;
  localparam int SETTLE_CYC   = 24;    // a full-depth transaction, its result, and margin
  localparam int STALL_LIMIT  = 4000;

  typedef struct {
    logic                                op;
    logic [lkvc_pkg::KEY_W-1:0]          key;
    logic signed [lkvc_pkg::VALUE_W-1:0] value;
  } cache_req_t;

  typedef struct {
    logic                                hit;
    logic signed [lkvc_pkg::VALUE_W-1:0] found_value;
  } lookup_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                op = lkvc_pkg::OP_INSERT;
  logic [lkvc_pkg::KEY_W-1:0]          key = '0;
  logic signed [lkvc_pkg::VALUE_W-1:0] value = '0;
  logic                                cfg_valid = 1'b0;
  logic [lkvc_pkg::CFG_W-1:0]          cfg_data = '0;
  logic                                busy;
  logic                                cfg_ready;
  logic                                result_valid;
  logic                                hit;
  logic signed [lkvc_pkg::VALUE_W-1:0] found_value;

  lru_key_value_cache #(.ENTRIES(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .key          (key),
    .value        (value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .hit          (hit),
    .found_value  (found_value)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Cache image kept by the testbench
  logic                                ent_valid [DEPTH];
  logic [lkvc_pkg::KEY_W-1:0]          ent_key   [DEPTH];
  logic signed [lkvc_pkg::VALUE_W-1:0] ent_value [DEPTH];
  logic [lkvc_pkg::STAMP_W-1:0]        ent_stamp [DEPTH];
  logic [lkvc_pkg::STAMP_W-1:0]        tick = '0;
  logic [lkvc_pkg::CFG_W-1:0]          active_cfg = lkvc_pkg::ENTRIES_IN_USE_RESET;

  cache_req_t     pending_q [$];
  lookup_result_t lookup_q  [$];
  logic [lkvc_pkg::KEY_W-1:0] key_pool [KEY_POOL];

  int  idle_pct = 25;
  logic item_taken = 1'b0;
  int  err_count = 0;
  int  n_items = 0;
  int  n_lookups = 0;
  int  n_hits = 0;
  int  n_cfg = 0;
  int  stall_cnt = 0;

  function automatic int clamp_entries(logic [lkvc_pkg::CFG_W-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > DEPTH) return DEPTH;
    return int'(cfg);
  endfunction

  // Apply one transaction to the cache image; lookups queue their result.
  function automatic void cache_access(cache_req_t req);
    int n;
    int match_i;
    int empty_i;
    int old_i;
    int slot;
    logic [lkvc_pkg::STAMP_W-1:0] old_stamp;
    lookup_result_t res;
    n = clamp_entries(active_cfg);
    match_i = -1;
    empty_i = -1;
    old_i = -1;
    old_stamp = '0;
    tick = tick + 1'b1;
    for (int i = 0; i < n; i++) begin
      if (ent_valid[i]) begin
        if (match_i < 0 && ent_key[i] == req.key) match_i = i;
        if (old_i < 0 || ent_stamp[i] < old_stamp) begin
          old_i = i;
          old_stamp = ent_stamp[i];
        end
      end else if (empty_i < 0) begin
        empty_i = i;
      end
    end
    if (req.op == lkvc_pkg::OP_LOOKUP) begin
      if (match_i >= 0) begin
        ent_stamp[match_i] = tick;
        res.hit = 1'b1;
        res.found_value = ent_value[match_i];
      end else begin
        res.hit = 1'b0;
        res.found_value = '0;
      end
      lookup_q.push_back(res);
    end else if (match_i >= 0) begin
      ent_value[match_i] = req.value;
      ent_stamp[match_i] = tick;
    end else begin
      slot = (empty_i >= 0) ? empty_i : old_i;
      ent_valid[slot] = 1'b1;
      ent_key[slot]   = req.key;
      ent_value[slot] = req.value;
      ent_stamp[slot] = tick;
    end
  endfunction

  task automatic log_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Driver: raise start at the falling edge, hold it until the block takes it
  always @(negedge clk) begin : drive
    cache_req_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // waiting for busy to drop
    end else if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
      nxt = pending_q.pop_front();
      start <= 1'b1;
      op    <= nxt.op;
      key   <= nxt.key;
      value <= nxt.value;
    end else begin
      start <= 1'b0;
      op    <= 1'($urandom_range(1));
      key   <= $urandom;
      value <= $urandom;
    end
  end

  // Monitor: predict on accepted transactions, check strobed results
  always @(posedge clk) begin : observe
    cache_req_t req;
    lookup_result_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      if (result_valid) begin
        if (lookup_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result hit=%0b value=%0d", hit, found_value));
        end else begin
          want = lookup_q.pop_front();
          if (hit !== want.hit)
            log_mismatch($sformatf("hit %0b, expected %0b", hit, want.hit));
          if (found_value !== want.found_value)
            log_mismatch($sformatf("found_value %0d, expected %0d",
                                   found_value, want.found_value));
        end
      end
      if (cfg_valid && cfg_ready) begin
        active_cfg = cfg_data;
        n_cfg++;
      end
      item_taken <= start && !busy;
      if (start && !busy) begin
        req.op = op;
        req.key = key;
        req.value = value;
        n_items++;
        if (op == lkvc_pkg::OP_LOOKUP) n_lookups++;
        cache_access(req);
        if (op == lkvc_pkg::OP_LOOKUP && lookup_q[$].hit) n_hits++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL lru_key_value_cache");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  task automatic add_item(input logic o, input logic [lkvc_pkg::KEY_W-1:0] k,
                          input logic signed [lkvc_pkg::VALUE_W-1:0] v);
    cache_req_t req;
    req.op = o;
    req.key = k;
    req.value = v;
    pending_q.push_back(req);
  endtask

  // Wait for the block to finish everything, including inserts in flight
  task automatic wait_idle();
    while (pending_q.size() != 0 || start || busy || lookup_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_entries(input logic [lkvc_pkg::CFG_W-1:0] n);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input logic [lkvc_pkg::CFG_W-1:0] cfg, input int idle,
                            input int count);
    int m;
    int lo;
    logic [lkvc_pkg::KEY_W-1:0] k;
    logic signed [lkvc_pkg::VALUE_W-1:0] v;
    write_entries(cfg);
    idle_pct = idle;
    // key window a little larger than the active set: hits, updates and evictions
    m = clamp_entries(cfg) + 3;
    lo = $urandom_range(KEY_POOL - m);
    @(posedge clk);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(lo + m - 1, lo)];
      case ($urandom_range(19))
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh7FFF_FFFF;
        default: v = $urandom;
      endcase
      add_item($urandom_range(1) ? lkvc_pkg::OP_LOOKUP : lkvc_pkg::OP_INSERT, k, v);
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i]   = '0;
      ent_value[i] = '0;
      ent_stamp[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty cache, field extremes, update, ignored lookup value
    idle_pct = 25;
    @(posedge clk);
    add_item(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'shFFFF_FFFF);
    add_item(lkvc_pkg::OP_INSERT, 32'h0000_0000, 32'sh8000_0000);
    add_item(lkvc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    add_item(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'sh0);
    add_item(lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'sh0);
    add_item(lkvc_pkg::OP_INSERT, 32'h0000_0000, 32'sh5);
    add_item(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'sh123);
    add_item(lkvc_pkg::OP_LOOKUP, 32'h0000_0001, 32'sh0);

    // Two entries: eviction of the least recently used one
    write_entries(5'd2);
    @(posedge clk);
    add_item(lkvc_pkg::OP_INSERT, 32'hA5A5_A5A5, 32'sh1);
    add_item(lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'sh0);
    add_item(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'sh0);
    add_item(lkvc_pkg::OP_INSERT, 32'h5A5A_5A5A, 32'shFFFF_FFFF);
    add_item(lkvc_pkg::OP_LOOKUP, 32'hA5A5_A5A5, 32'sh0);

    // Zero acts as one entry; the hidden entry gets a duplicate key
    write_entries(5'd0);
    @(posedge clk);
    add_item(lkvc_pkg::OP_INSERT, 32'h5A5A_5A5A, 32'sh7);
    add_item(lkvc_pkg::OP_LOOKUP, 32'h5A5A_5A5A, 32'sh0);
    add_item(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'sh0);

    // Above depth acts as full depth; lowest index wins among duplicates
    write_entries(5'd31);
    @(posedge clk);
    add_item(lkvc_pkg::OP_LOOKUP, 32'h5A5A_5A5A, 32'sh0);
    add_item(lkvc_pkg::OP_INSERT, 32'h0000_0001, 32'sh2);
    add_item(lkvc_pkg::OP_LOOKUP, 32'h0000_0001, 32'sh0);

    run_random(5'd16, 25, 200);
    run_random(5'd1,  25, 100);
    run_random(5'd0,  25, 60);
    run_random(5'd4,  81, 200);
    run_random(5'd31, 81, 100);
    run_random(5'd2,  0,  150);
    run_random(5'd17, 0,  100);
    run_random(5'd8,  0,  200);
    run_random(5'd16, 0,  100);

    wait_idle();
    $display("run covered %0d transactions: %0d lookups, %0d hits", n_items, n_lookups, n_hits);
    $display("entries_in_use written %0d times, including 0, 1, 16, 17 and 31", n_cfg);
    if (err_count == 0) begin
      $display("PASS lru_key_value_cache");
    end else begin
      $display("FAIL lru_key_value_cache");
    end
    $finish;
  end

endmodule
